// ===== rtl/iqtlv_pkg.sv =====
// ----------------------------------------------------------------------------
// iqtlv_pkg
// Shared types and constants of the quality-value TLV encoder.
// ----------------------------------------------------------------------------
package iqtlv_pkg;

	localparam int FRAME_BYTES = 17;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	// function codes
	localparam logic FUNC_STATEQ = 1'b0;
	localparam logic FUNC_REALQ  = 1'b1;

	// tags and fixed lengths
	localparam logic [7:0] TAG_STATEQ = 8'hA2;
	localparam logic [7:0] TAG_REALQ  = 8'hA3;
	localparam logic [7:0] TAG_INT    = 8'h02;
	localparam logic [7:0] TAG_QUAL   = 8'h85;
	localparam logic [7:0] TAG_TIME   = 8'h17;
	localparam logic [7:0] LEN_QUAL   = 8'h01;
	localparam logic [7:0] LEN_TIME   = 8'h04;

	localparam logic [7:0] MASK_RESET = 8'h3F;

	typedef logic [0:FRAME_BYTES-1][7:0] frame_t;

	typedef struct packed {
		logic               func;
		logic [1:0]         state_code;
		logic signed [31:0] milli;
		logic [7:0]         flags;
		logic               has_time;
		logic [31:0]        time_value;
		logic [7:0]         capacity;
	} req_t;

	typedef struct packed {
		frame_t             frame;
		logic [LEN_W-1:0]   total;
		logic               overflow;
	} build_t;

endpackage

// ===== rtl/iqtlv_if.sv =====
// ----------------------------------------------------------------------------
// iqtlv_req_if / iqtlv_rsp_if
// Valid/ready channels for encode requests and encoded bytes.
// ----------------------------------------------------------------------------
interface iqtlv_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [1:0]         state_code;
	logic signed [31:0] milli;
	logic [7:0]         flags;
	logic               has_time;
	logic [31:0]        time_value;
	logic [7:0]         capacity;

	modport source (output valid, func, state_code, milli, flags, has_time, time_value,
		capacity, input ready);
	modport sink (input valid, func, state_code, milli, flags, has_time, time_value,
		capacity, output ready);
endinterface

interface iqtlv_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       overflow;
	logic [4:0] frame_length;

	modport source (output valid, out_byte, last, overflow, frame_length, input ready);
	modport sink (input valid, out_byte, last, overflow, frame_length, output ready);
endinterface

// ===== rtl/iccp_quality_value_tlv_encoder_top.sv =====
// ----------------------------------------------------------------------------
// iccp_quality_value_tlv_encoder_top
// Encode StateQ / RealQ quality values as BER short-form TLV byte frames.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-----------------------------------------
//   req     | in  | valid/ready      | func, state_code, milli, flags, ...
//   rsp     | out | valid/ready      | out_byte, last, overflow, frame_length
//   cfg     | in  | cfg_we (no wait) | cfg_wdata -> quality_mask
//
// One request yields one beat per frame byte (5 to 17) or a single overflow
// beat; the byte serializer sets the rate, one beat per cycle while rsp is ready.
// The first beat passes the request register, frame store and output register.
// A new request is taken while the previous frame is still being sent.
// Reset clears all valid flags and sets quality_mask to 0x3F.
// A stalled rsp holds the current beat and the frame pointer.
// ----------------------------------------------------------------------------
module iccp_quality_value_tlv_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	iqtlv_req_if.sink   req,
	iqtlv_rsp_if.source rsp
);

	logic [7:0]        mask_q;
	logic              valid_s1;
	iqtlv_pkg::req_t   req_s1;
	iqtlv_pkg::build_t bld;
	logic              free;
	logic              load;

	// quality mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= iqtlv_pkg::MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// request register
	assign load      = valid_s1 && free;
	assign req.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.func       <= req.func;
			req_s1.state_code <= req.state_code;
			req_s1.milli      <= req.milli;
			req_s1.flags      <= req.flags;
			req_s1.has_time   <= req.has_time;
			req_s1.time_value <= req.time_value;
			req_s1.capacity   <= req.capacity;
		end
	end

	iqtlv_build u_build (
		.req  (req_s1),
		.mask (mask_q),
		.bld  (bld)
	);

	iqtlv_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.bld    (bld),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/iqtlv_build.sv =====
// ----------------------------------------------------------------------------
// iqtlv_build
// Assemble the whole TLV frame, its length and the overflow flag in one pass.
// ----------------------------------------------------------------------------
module iqtlv_build (
	input  iqtlv_pkg::req_t   req,
	input  logic [7:0]        mask,
	output iqtlv_pkg::build_t bld
);

	logic [7:0]   b0, b1, b2, b3;
	logic         c0, c1, c2;
	logic [1:0]   start;
	logic [2:0]   il;
	logic [7:0]   q;
	logic [7:0]   sq;
	logic [71:0]  tail;
	logic [103:0] body;
	logic [103:0] shifted;
	logic [4:0]   n;
	logic [7:0]   n8;

	assign {b0, b1, b2, b3} = req.milli;

	// drop redundant sign bytes of the integer, at most three
	assign c0 = (b0 == 8'h00 && !b1[7]) || (b0 == 8'hFF && b1[7]);
	assign c1 = (b1 == 8'h00 && !b2[7]) || (b1 == 8'hFF && b2[7]);
	assign c2 = (b2 == 8'h00 && !b3[7]) || (b2 == 8'hFF && b3[7]);

	always_comb begin
		if (!c0) begin
			start = 2'd0;
		end else if (!c1) begin
			start = 2'd1;
		end else if (!c2) begin
			start = 2'd2;
		end else begin
			start = 2'd3;
		end
	end

	assign il = 3'd4 - {1'b0, start};

	// masked quality, with state on top for StateQ
	assign q  = req.flags & mask;
	assign sq = {req.state_code, 6'b0} | q;

	// integer content followed by quality and time TLVs, aligned past dropped bytes
	assign tail    = {iqtlv_pkg::TAG_QUAL, iqtlv_pkg::LEN_QUAL, q,
		iqtlv_pkg::TAG_TIME, iqtlv_pkg::LEN_TIME, req.time_value};
	assign body    = {req.milli, tail};
	assign shifted = body << {start, 3'b000};

	// inner length
	always_comb begin
		if (req.func == iqtlv_pkg::FUNC_STATEQ) begin
			n = 5'd3;
		end else begin
			n = 5'd5 + {2'b0, il};
		end
		if (req.has_time) begin
			n = n + 5'd6;
		end
	end

	assign n8 = {3'b0, n};

	always_comb begin
		if (req.func == iqtlv_pkg::FUNC_STATEQ) begin
			bld.frame = {iqtlv_pkg::TAG_STATEQ, n8, iqtlv_pkg::TAG_QUAL, iqtlv_pkg::LEN_QUAL,
				sq, iqtlv_pkg::TAG_TIME, iqtlv_pkg::LEN_TIME, req.time_value, 48'b0};
		end else begin
			bld.frame = {iqtlv_pkg::TAG_REALQ, n8, iqtlv_pkg::TAG_INT, {5'b0, il}, shifted};
		end
	end

	assign bld.total    = n + 5'd2;
	assign bld.overflow = {3'b0, bld.total} > req.capacity;

endmodule

// ===== rtl/iqtlv_ser.sv =====
// ----------------------------------------------------------------------------
// iqtlv_ser
// Hold one built frame and send it out one byte per beat through a register.
// ----------------------------------------------------------------------------
module iqtlv_ser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  iqtlv_pkg::build_t bld,
	output logic              free,
	iqtlv_rsp_if.source       rsp
);

	iqtlv_pkg::frame_t             frame_q;
	logic [iqtlv_pkg::LEN_W-1:0]   len_q;
	logic                          ovf_q;
	logic [iqtlv_pkg::IDX_W-1:0]   idx_q;
	logic                          busy_q;
	logic                          valid_q;
	logic [7:0]                    byte_q;
	logic                          last_q;
	logic                          oflag_q;
	logic [iqtlv_pkg::LEN_W-1:0]   flen_q;
	logic                          emit;
	logic                          done;

	assign emit = busy_q && (!valid_q || rsp.ready);
	assign done = ovf_q || (idx_q == len_q - 5'd1);
	assign free = !busy_q || (emit && done);

	// frame store and byte pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (emit) begin
				if (done) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= bld.frame;
			len_q   <= bld.total;
			ovf_q   <= bld.overflow;
		end
	end

	// output register: advance on emit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= ovf_q ? 8'h00 : frame_q[idx_q];
			last_q  <= done;
			oflag_q <= ovf_q;
			flen_q  <= ovf_q ? '0 : len_q;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.out_byte     = byte_q;
	assign rsp.last         = last_q;
	assign rsp.overflow     = oflag_q;
	assign rsp.frame_length = flen_q;

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && oflag_q |-> last_q && flen_q == 5'd0 && byte_q == 8'h00)
		else $error("overflow beat malformed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !ovf_q |-> len_q >= 5'd5 && len_q <= 5'd17)
		else $error("frame length out of range");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !ovf_q |-> idx_q < len_q)
		else $error("byte pointer past frame end");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("frame loaded while previous still sending");

endmodule
